[rtl/core/cbpg_pkg.sv]
package cbpg_pkg;

  localparam int CW   = 16;
  localparam int WW   = 17;
  localparam int IDXW = 6;
  localparam int PW   = WW + CW + 1;
  localparam int SW   = PW + 1;
  localparam int TW   = PW + 2;
  localparam int FRAC = 16;
  localparam int QW   = TW - FRAC;

  localparam longint unsigned WEIGHT_ONE = 64'd65536;

  localparam logic signed [TW-1:0] ROUND_BIAS = TW'(32768);
  localparam logic signed [QW-1:0] Q_MAX      = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN      = -QW'(32768);
  localparam logic signed [CW-1:0] C_MAX      = 16'sh7fff;
  localparam logic signed [CW-1:0] C_MIN      = 16'sh8000;

  typedef struct packed {
    logic signed [CW-1:0] p0_x;
    logic signed [CW-1:0] p0_y;
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
    logic signed [CW-1:0] p3_x;
    logic signed [CW-1:0] p3_y;
  } cbpg_in_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic [IDXW-1:0]      step_index;
    logic                 last_point;
  } cbpg_out_t;

  typedef logic [3:0][WW-1:0] cbpg_wvec_t;
  typedef logic [3:0][CW-1:0] cbpg_pvec_t;

  typedef struct packed {
    logic            vld;
    logic [IDXW-1:0] k;
    logic            last;
    cbpg_wvec_t      w;
    cbpg_pvec_t      px;
    cbpg_pvec_t      py;
  } cbpg_issue_t;

  typedef struct packed {
    logic            vld;
    logic [IDXW-1:0] k;
    logic            last;
  } cbpg_meta_t;

endpackage

[rtl/core/cbpg_seq.sv]
module cbpg_seq
  import cbpg_pkg::*;
#(
  parameter int STEPS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  cbpg_in_t    in_data,
  output logic        in_stall,
  output cbpg_issue_t iss
);

  localparam int KW = $clog2(STEPS + 1);
  localparam longint unsigned N   = longint'(STEPS);
  localparam longint unsigned DEN = N * N * N;

  cbpg_wvec_t wtab [STEPS+1];

  for (genvar g = 0; g <= STEPS; g++) begin : g_wtab
    localparam longint unsigned K = longint'(g);
    localparam longint unsigned M = N - K;
    localparam longint unsigned W0 = (M * M * M * WEIGHT_ONE + DEN / 2) / DEN;
    localparam longint unsigned W1 = (3 * M * M * K * WEIGHT_ONE + DEN / 2) / DEN;
    localparam longint unsigned W2 = (3 * M * K * K * WEIGHT_ONE + DEN / 2) / DEN;
    localparam longint unsigned W3 = (K * K * K * WEIGHT_ONE + DEN / 2) / DEN;
    assign wtab[g] = {WW'(W3), WW'(W2), WW'(W1), WW'(W0)};
  end

  logic           busy_r, busy_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  cbpg_in_t       seg_r, seg_nxt;
  cbpg_issue_t    iss_r, iss_nxt;
  logic           at_end;
  logic           take;

  assign at_end   = (k_r == KW'(STEPS));
  assign in_stall = busy_r && !(adv && at_end);
  assign take     = in_valid && !in_stall;
  assign iss      = iss_r;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    seg_nxt  = seg_r;
    iss_nxt  = iss_r;
    if (adv) begin
      iss_nxt.vld  = busy_r;
      iss_nxt.k    = IDXW'(k_r);
      iss_nxt.last = at_end;
      iss_nxt.w    = wtab[k_r];
      iss_nxt.px   = {seg_r.p3_x, seg_r.p2_x, seg_r.p1_x, seg_r.p0_x};
      iss_nxt.py   = {seg_r.p3_y, seg_r.p2_y, seg_r.p1_y, seg_r.p0_y};
      if (busy_r) begin
        k_nxt = k_r + 1'b1;
        if (at_end) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      seg_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    k_r   <= k_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      iss_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      iss_r  <= iss_nxt;
    end
  end

endmodule

[rtl/core/cbpg_lane.sv]
module cbpg_lane
  import cbpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 adv,
  input  cbpg_wvec_t           w,
  input  cbpg_pvec_t           p,
  output logic signed [CW-1:0] res
);

  logic signed [PW-1:0] prod_r [4];
  logic signed [PW-1:0] prod_nxt [4];
  logic signed [SW-1:0] s01_r, s23_r, s01_nxt, s23_nxt;
  logic signed [CW-1:0] res_r, res_nxt;
  logic signed [TW-1:0] tot;
  logic signed [QW-1:0] q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = $signed({1'b0, w[i]}) * $signed(p[i]);
    end
    s01_nxt = SW'(prod_r[0]) + SW'(prod_r[1]);
    s23_nxt = SW'(prod_r[2]) + SW'(prod_r[3]);
    tot     = TW'(s01_r) + TW'(s23_r) + ROUND_BIAS;
    q       = tot[TW-1:FRAC];
    if (q > Q_MAX) begin
      res_nxt = C_MAX;
    end else if (q < Q_MIN) begin
      res_nxt = C_MIN;
    end else begin
      res_nxt = q[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      s01_r  <= s01_nxt;
      s23_r  <= s23_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[rtl/core/cubic_bezier_point_generator.sv]
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | cbpg_in_t: four control points, Q12.4
// out     | output    | out_valid/out_stall | cbpg_out_t: point, step_index, last_point
// Each segment yields STEPS+1 points, one per cycle while out is not stalled; the
// sequencer's step counter sets this count. After acceptance each point passes the
// stages issue, multiply, pair add and sum/round/saturate in that order.
// Reset is synchronous active low and clears the valid bits and the sequencer's busy flag.
// A stall on out while out_valid is high freezes the whole pipeline; nothing is dropped or repeated.
// The next segment is taken in the cycle the last point of the current one issues.
module cubic_bezier_point_generator
  import cbpg_pkg::*;
#(
  parameter int STEPS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cbpg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cbpg_out_t out_data
);

  cbpg_issue_t iss;
  cbpg_meta_t  m1_r, m2_r, m3_r;
  logic        adv;
  logic signed [CW-1:0] rx, ry;

  assign adv = !(m3_r.vld && out_stall);

  cbpg_seq #(.STEPS(STEPS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .iss      (iss)
  );

  cbpg_lane u_lane_x (
    .clk (clk),
    .adv (adv),
    .w   (iss.w),
    .p   (iss.px),
    .res (rx)
  );

  cbpg_lane u_lane_y (
    .clk (clk),
    .adv (adv),
    .w   (iss.w),
    .p   (iss.py),
    .res (ry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '0;
      m2_r <= '0;
      m3_r <= '0;
    end else if (adv) begin
      m1_r <= '{vld: iss.vld, k: iss.k, last: iss.last};
      m2_r <= m1_r;
      m3_r <= m2_r;
    end
  end

  assign out_valid           = m3_r.vld;
  assign out_data.point_x    = rx;
  assign out_data.point_y    = ry;
  assign out_data.step_index = m3_r.k;
  assign out_data.last_point = m3_r.last;

endmodule

[rtl/core/cbpg_chk.sv]
module cbpg_chk
  import cbpg_pkg::*;
#(
  parameter int STEPS = 32
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input cbpg_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input cbpg_out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("in transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out transaction changed while stalled");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_point == (out_data.step_index == IDXW'(STEPS))))
    else $error("last_point does not match final step");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.step_index <= IDXW'(STEPS))
    else $error("step_index beyond STEPS");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second in transaction taken while segment in progress");

endmodule

bind cubic_bezier_point_generator cbpg_chk #(.STEPS(STEPS)) u_cbpg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
